@@ hdl/memory_pattern_test_sequencer_top_assert.svh @@
`ifndef MEMORY_PATTERN_TEST_SEQUENCER_TOP_ASSERT_SVH
`define MEMORY_PATTERN_TEST_SEQUENCER_TOP_ASSERT_SVH

// implication checked in the same cycle
`define MPTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define MPTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mpts_pkg.sv @@
package mpts_pkg;

    localparam int ADDR_WIDTH_DEF = 32;
    localparam int LINE_BYTES_DEF = 32;

    localparam logic [31:0] BASE_RESET = 32'h0000_0000;
    localparam logic [31:0] SIZE_RESET = 32'h0010_0000;
    localparam logic [1:0]  MODE_RESET = 2'd0;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;
    localparam logic [1:0] CFG_MODE = 2'd2;

    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_TYPE0   = 2'd1;
    localparam logic [1:0] MODE_CACHE   = 2'd2;
    localparam logic [1:0] MODE_ALL_ALT = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DONE  = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [1:0] PH_PATTERN = 2'd0;
    localparam logic [1:0] PH_ADDR    = 2'd1;
    localparam logic [1:0] PH_STRIDE  = 2'd2;
    localparam logic [1:0] PH_VERIFY  = 2'd3;

    localparam logic [1:0] PR_NONE    = 2'd0;
    localparam logic [1:0] PR_DISCARD = 2'd1;
    localparam logic [1:0] PR_CHECK   = 2'd2;
    localparam logic [1:0] PR_WRITE   = 2'd3;

    localparam logic [3:0] LAST_TYPE  = 4'hF;
    localparam logic [1:0] LAST_ROUND = 2'd3;

    localparam logic [31:0] PATTERN_SET [8][4] = '{
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555},
        '{32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
        '{32'h0000_0000, 32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA}
    };

    typedef enum logic {
        ST_WAIT,
        ST_SETTLE
    } eng_state_t;

    typedef struct packed {
        logic        op;
        logic [31:0] rd;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic        failed;
        logic [31:0] expected;
        logic [31:0] observed;
        logic [3:0]  ttype;
        logic [1:0]  phase;
    } res_t;

    function automatic logic [31:0] addr_word(input logic [31:0] a, input logic odd);
        logic [31:0] w;
        if (odd) begin
            w = {a[31:16], ~a[15:0]};
        end else begin
            w = {~a[31:16], a[15:0]};
        end
        return w;
    endfunction

endpackage

@@ hdl/mpts_front.sv @@
module mpts_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mpts_pkg::item_t     in_item,
    output logic                q_valid,
    output mpts_pkg::item_t     q_item,
    input  logic                q_pop
);

    mpts_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hdl/mpts_engine.sv @@
module mpts_engine #(
    parameter int ADDR_WIDTH = mpts_pkg::ADDR_WIDTH_DEF,
    parameter int LINE_BYTES = mpts_pkg::LINE_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      base_address,
    input  logic [31:0]      size_bytes,
    input  logic [1:0]       sweep_mode,
    input  logic             q_valid,
    input  mpts_pkg::item_t  q_item,
    output logic             q_pop,
    input  logic             out_free,
    output logic             res_valid,
    output mpts_pkg::res_t   res
);

    localparam int AW   = ADDR_WIDTH;
    localparam int WPL  = LINE_BYTES / 4;
    localparam int LOW  = (WPL > 1) ? $clog2(WPL) : 1;
    localparam int SW   = (AW > 34) ? AW : 34;
    localparam logic [LOW-1:0] LAST_LINE = LOW'(WPL - 1);

    mpts_pkg::eng_state_t state_reg, state_next;

    logic           busy_reg, busy_next;
    logic [1:0]     phase_reg, phase_next;
    logic           vp_reg, vp_next;
    logic [3:0]     type_reg, type_next;
    logic [1:0]     round_reg, round_next;
    logic [29:0]    wi_reg, wi_next;
    logic [LOW-1:0] lo_reg, lo_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  tp_reg, tp_next;
    logic [1:0]     pr_reg, pr_next;
    logic [31:0]    pe_reg, pe_next;

    logic [SW-1:0]  base_ext, sum_end, sum_word, sum_line;
    logic [AW-1:0]  base_aw, range_end, word_addr, line_addr, cur_addr;
    logic [AW:0]    wp_inc;
    logic           wp_carry;
    logic [29:0]    word_count;
    logic [31:0]    a32, pat_word, val;
    logic           mismatch, more_types, odd_type;
    logic           issue_ok, finish_ok, emit_settle;
    logic           take;

    assign base_ext   = SW'(base_address);
    assign sum_end    = base_ext + SW'(size_bytes);
    assign sum_word   = base_ext + (SW'(wi_reg) << 2);
    assign sum_line   = base_ext + ((SW'(lo_reg) + SW'(1)) << 2);
    assign base_aw    = base_ext[AW-1:0];
    assign range_end  = sum_end[AW-1:0];
    assign word_addr  = sum_word[AW-1:0];
    assign line_addr  = sum_line[AW-1:0];
    assign word_count = size_bytes[31:2];
    assign wp_inc     = {1'b0, wp_reg} + (AW+1)'(LINE_BYTES);
    assign wp_carry   = wp_inc[AW];
    assign odd_type   = type_reg[0];
    assign more_types = ((sweep_mode == mpts_pkg::MODE_ALL) ||
                         (sweep_mode == mpts_pkg::MODE_ALL_ALT)) &&
                        (type_reg != mpts_pkg::LAST_TYPE);

    always_comb begin
        if (phase_reg <= mpts_pkg::PH_ADDR) begin
            cur_addr = word_addr;
        end else if (phase_reg == mpts_pkg::PH_STRIDE && vp_reg) begin
            cur_addr = tp_reg;
        end else begin
            cur_addr = wp_reg;
        end
    end

    assign a32      = 32'(cur_addr);
    assign pat_word = mpts_pkg::PATTERN_SET[type_reg[3:1]][wi_reg[1:0] + round_reg];
    assign mismatch = (pr_reg == mpts_pkg::PR_CHECK) && (q_item.rd != pe_reg);
    assign take     = (state_reg == mpts_pkg::ST_WAIT) && q_valid && out_free;

    always_comb begin
        if (phase_reg == mpts_pkg::PH_PATTERN) begin
            val = pat_word;
        end else if (phase_reg == mpts_pkg::PH_ADDR) begin
            val = mpts_pkg::addr_word(a32, wi_reg[0]);
        end else begin
            val = a32 + 32'(round_reg);
        end
    end

    always_comb begin
        if (phase_reg <= mpts_pkg::PH_ADDR) begin
            issue_ok = (wi_reg < word_count);
        end else if (phase_reg == mpts_pkg::PH_STRIDE) begin
            issue_ok = vp_reg || (wp_reg < range_end);
        end else begin
            issue_ok = (wp_reg < range_end);
        end
        finish_ok   = (phase_reg == mpts_pkg::PH_VERIFY) && !issue_ok &&
                      (lo_reg == LAST_LINE) && (round_reg == mpts_pkg::LAST_ROUND) &&
                      !more_types;
        emit_settle = issue_ok || finish_ok;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mpts_pkg::ST_WAIT: begin
                if (take && ((q_item.op == mpts_pkg::OP_START) || (busy_reg && !mismatch))) begin
                    state_next = mpts_pkg::ST_SETTLE;
                end
            end
            mpts_pkg::ST_SETTLE: begin
                if (emit_settle && out_free) begin
                    state_next = mpts_pkg::ST_WAIT;
                end
            end
            default: state_next = mpts_pkg::ST_WAIT;
        endcase
    end

    // outputs and sequencer datapath
    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        vp_next    = vp_reg;
        type_next  = type_reg;
        round_next = round_reg;
        wi_next    = wi_reg;
        lo_next    = lo_reg;
        wp_next    = wp_reg;
        tp_next    = tp_reg;
        pr_next    = pr_reg;
        pe_next    = pe_reg;
        q_pop      = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        res.ttype  = type_reg;
        res.phase  = phase_reg;
        unique case (state_reg)
            mpts_pkg::ST_WAIT: begin
                if (take) begin
                    q_pop = 1'b1;
                    if (q_item.op == mpts_pkg::OP_START) begin
                        busy_next  = 1'b1;
                        type_next  = '0;
                        phase_next = (sweep_mode == mpts_pkg::MODE_CACHE) ?
                                     mpts_pkg::PH_STRIDE : mpts_pkg::PH_PATTERN;
                        round_next = '0;
                        wi_next    = '0;
                        lo_next    = '0;
                        vp_next    = 1'b0;
                        wp_next    = base_aw;
                        tp_next    = base_aw;
                        pr_next    = mpts_pkg::PR_NONE;
                        pe_next    = '0;
                    end else if (!busy_reg) begin
                        res_valid = 1'b1;
                        res.kind  = mpts_pkg::KIND_NONE;
                    end else if (mismatch) begin
                        busy_next    = 1'b0;
                        pr_next      = mpts_pkg::PR_NONE;
                        res_valid    = 1'b1;
                        res.kind     = mpts_pkg::KIND_FINISH;
                        res.addr     = a32;
                        res.failed   = 1'b1;
                        res.expected = pe_reg;
                        res.observed = q_item.rd;
                    end else begin
                        if (phase_reg <= mpts_pkg::PH_ADDR) begin
                            if (!((phase_reg == mpts_pkg::PH_PATTERN) && !vp_reg && odd_type &&
                                  (pr_reg == mpts_pkg::PR_DISCARD))) begin
                                wi_next = wi_reg + 30'd1;
                            end
                        end else if (phase_reg == mpts_pkg::PH_STRIDE) begin
                            if (vp_reg) begin
                                tp_next = tp_reg + AW'(LINE_BYTES);
                                vp_next = 1'b0;
                            end else if (wp_carry) begin
                                wp_next = range_end;
                            end else begin
                                wp_next = wp_inc[AW-1:0];
                                if ((range_end >> 1) <= wp_inc[AW-1:0]) begin
                                    vp_next = 1'b1;
                                end
                            end
                        end else begin
                            wp_next = wp_carry ? range_end : wp_inc[AW-1:0];
                        end
                    end
                end
            end
            mpts_pkg::ST_SETTLE: begin
                if (issue_ok) begin
                    if (out_free) begin
                        res_valid = 1'b1;
                        res.addr  = a32;
                        if ((phase_reg <= mpts_pkg::PH_ADDR && vp_reg) ||
                            (phase_reg == mpts_pkg::PH_STRIDE && vp_reg) ||
                            (phase_reg == mpts_pkg::PH_VERIFY)) begin
                            pr_next  = mpts_pkg::PR_CHECK;
                            pe_next  = val;
                            res.kind = mpts_pkg::KIND_READ;
                        end else if ((phase_reg == mpts_pkg::PH_PATTERN) && odd_type &&
                                     (pr_reg != mpts_pkg::PR_DISCARD)) begin
                            pr_next  = mpts_pkg::PR_DISCARD;
                            pe_next  = '0;
                            res.kind = mpts_pkg::KIND_READ;
                        end else begin
                            pr_next   = mpts_pkg::PR_WRITE;
                            pe_next   = '0;
                            res.kind  = mpts_pkg::KIND_WRITE;
                            res.wdata = val;
                        end
                    end
                end else if (finish_ok) begin
                    if (out_free) begin
                        busy_next = 1'b0;
                        pr_next   = mpts_pkg::PR_NONE;
                        res_valid = 1'b1;
                        res.kind  = mpts_pkg::KIND_FINISH;
                    end
                end else if (phase_reg <= mpts_pkg::PH_ADDR) begin
                    wi_next = '0;
                    if (!vp_reg) begin
                        vp_next = 1'b1;
                    end else if (phase_reg == mpts_pkg::PH_PATTERN &&
                                 round_reg != mpts_pkg::LAST_ROUND) begin
                        round_next = round_reg + 2'd1;
                        vp_next    = 1'b0;
                    end else if (phase_reg == mpts_pkg::PH_PATTERN) begin
                        phase_next = mpts_pkg::PH_ADDR;
                        vp_next    = 1'b0;
                    end else begin
                        phase_next = mpts_pkg::PH_STRIDE;
                        round_next = '0;
                        vp_next    = 1'b0;
                        lo_next    = '0;
                        wp_next    = base_aw;
                        tp_next    = base_aw;
                    end
                end else if (lo_reg != LAST_LINE) begin
                    lo_next = lo_reg + LOW'(1);
                    wp_next = line_addr;
                    tp_next = line_addr;
                end else if (phase_reg == mpts_pkg::PH_STRIDE) begin
                    phase_next = mpts_pkg::PH_VERIFY;
                    lo_next    = '0;
                    wp_next    = base_aw;
                    tp_next    = base_aw;
                end else if (round_reg != mpts_pkg::LAST_ROUND) begin
                    round_next = round_reg + 2'd1;
                    phase_next = mpts_pkg::PH_STRIDE;
                    vp_next    = 1'b0;
                    lo_next    = '0;
                    wp_next    = base_aw;
                    tp_next    = base_aw;
                end else begin
                    // next test type
                    type_next  = type_reg + 4'd1;
                    phase_next = (sweep_mode == mpts_pkg::MODE_CACHE) ?
                                 mpts_pkg::PH_STRIDE : mpts_pkg::PH_PATTERN;
                    round_next = '0;
                    wi_next    = '0;
                    lo_next    = '0;
                    vp_next    = 1'b0;
                    wp_next    = base_aw;
                    tp_next    = base_aw;
                    pr_next    = mpts_pkg::PR_NONE;
                    pe_next    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpts_pkg::ST_WAIT;
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            vp_reg    <= 1'b0;
            type_reg  <= '0;
            round_reg <= '0;
            wi_reg    <= '0;
            lo_reg    <= '0;
            wp_reg    <= '0;
            tp_reg    <= '0;
            pr_reg    <= mpts_pkg::PR_NONE;
            pe_reg    <= '0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            vp_reg    <= vp_next;
            type_reg  <= type_next;
            round_reg <= round_next;
            wi_reg    <= wi_next;
            lo_reg    <= lo_next;
            wp_reg    <= wp_next;
            tp_reg    <= tp_next;
            pr_reg    <= pr_next;
            pe_reg    <= pe_next;
        end
    end

endmodule

@@ hdl/memory_pattern_test_sequencer_top.sv @@
// path: queue, engine take, engine issue, output register; idle or failing requests skip issue
// a new request is taken only after the last result is issued; both steps wait for output room
// each empty pass, line or skipped type is stepped over in the settle state before the result
// the 2-entry request queue keeps taking requests, until full, while a result waits on m_axis
// reset: synchronous active-low aresetn; idle, config back to base 0, size 1 MiB, mode 0
`include "memory_pattern_test_sequencer_top_assert.svh"

module memory_pattern_test_sequencer_top #(
    parameter int ADDR_WIDTH = mpts_pkg::ADDR_WIDTH_DEF,
    parameter int LINE_BYTES = mpts_pkg::LINE_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // read_data
    input  logic [0:0]   s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // access_address, write_data, run_failed, expected_word, observed_word,
    // current_type, current_phase, zero pad
    output logic [135:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // access_kind
);

    logic [31:0] base_reg;
    logic [31:0] size_reg;
    logic [1:0]  mode_reg;

    mpts_pkg::item_t in_item, q_item;
    mpts_pkg::res_t  res, res_reg;
    logic            q_valid, q_pop, res_valid, out_free;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= mpts_pkg::BASE_RESET;
            size_reg <= mpts_pkg::SIZE_RESET;
            mode_reg <= mpts_pkg::MODE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mpts_pkg::CFG_BASE: base_reg <= cfg_wr_data;
                mpts_pkg::CFG_SIZE: size_reg <= cfg_wr_data;
                mpts_pkg::CFG_MODE: mode_reg <= cfg_wr_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.op = s_axis_tuser[0];
    assign in_item.rd = s_axis_tdata;

    mpts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mpts_engine #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .LINE_BYTES (LINE_BYTES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .base_address (base_reg),
        .size_bytes   (size_reg),
        .sweep_mode   (mode_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output register
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {1'b0, res_reg.phase, res_reg.ttype, res_reg.observed,
                            res_reg.expected, res_reg.failed, res_reg.wdata, res_reg.addr};

    `MPTS_ASSERT_NOW(a_emit_has_room, res_valid, out_free, "result produced with output full")
    `MPTS_ASSERT_NOW(a_fail_is_finish, m_axis_tvalid && m_axis_tdata[64],
        m_axis_tuser == mpts_pkg::KIND_FINISH, "failure flag without finish")
    `MPTS_ASSERT_NOW(a_pop_needs_room, q_pop, out_free, "request taken without result space")
    `MPTS_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "result dropped while stalled")

endmodule
